// ----- design/slsg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_pkg
// Types, register map and constants of the stop line speed governor.
// ----------------------------------------------------------------------------
package slsg_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned DivSteps = 33;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  typedef enum logic [2:0] {
    REG_STOP_MARGIN      = 3'd0,
    REG_BRAKE_LATENCY    = 3'd1,
    REG_STOP_BEGIN_RANGE = 3'd2,
    REG_MAX_DECELERATION = 3'd3,
    REG_CREEP_RANGE_MAX  = 3'd4,
    REG_CREEP_SPEED      = 3'd5,
    REG_BUMPER_OFFSET    = 3'd6,
    REG_SPEED_EPSILON    = 3'd7
  } cfg_idx_e;

  localparam logic [30:0] StopMarginRst      = 31'd65536;
  localparam logic [30:0] BrakeLatencyRst    = 31'd0;
  localparam logic [30:0] StopBeginRangeRst  = 31'd65536;
  localparam logic [30:0] MaxDecelerationRst = 31'd65536;
  localparam logic [30:0] CreepRangeMaxRst   = 31'd196608;
  localparam logic [30:0] CreepSpeedRst      = 31'd32768;
  localparam logic [30:0] BumperOffsetRst    = 31'd229376;
  localparam logic [30:0] SpeedEpsilonRst    = 31'd655;

  typedef struct packed {
    logic [30:0] stop_margin;
    logic [30:0] brake_latency;
    logic [30:0] stop_begin_range;
    logic [30:0] max_deceleration;
    logic [30:0] creep_range_max;
    logic [30:0] creep_speed;
    logic [30:0] bumper_offset;
    logic [30:0] speed_epsilon;
  } cfg_t;

  typedef struct packed {
    logic               opcode;
    logic [30:0]        waypoint_distance;
    logic signed [31:0] measured_speed;
    logic signed [31:0] requested_speed;
    logic [30:0]        top_speed;
    logic               inside_stop_polygon;
  } slsg_in_t;

  typedef struct packed {
    logic signed [31:0] commanded_speed;
    logic               finished;
    logic               is_stopping;
    logic               is_creeping;
  } slsg_out_t;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAT,
    ST_DIST,
    ST_SQ,
    ST_DSTART,
    ST_DIV,
    ST_DEC
  } slsg_state_e;

endpackage

// ----- design/slsg_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface slsg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/slsg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_regs
// APB-style configuration register file of the governor.
// ----------------------------------------------------------------------------
module slsg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slsg_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output slsg_pkg::cfg_t                cfg_o
);

  slsg_pkg::cfg_t       cfg_q;
  slsg_pkg::cfg_idx_e   idx;
  logic                 wr_en;

  assign idx    = slsg_pkg::cfg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_margin      <= slsg_pkg::StopMarginRst;
      cfg_q.brake_latency    <= slsg_pkg::BrakeLatencyRst;
      cfg_q.stop_begin_range <= slsg_pkg::StopBeginRangeRst;
      cfg_q.max_deceleration <= slsg_pkg::MaxDecelerationRst;
      cfg_q.creep_range_max  <= slsg_pkg::CreepRangeMaxRst;
      cfg_q.creep_speed      <= slsg_pkg::CreepSpeedRst;
      cfg_q.bumper_offset    <= slsg_pkg::BumperOffsetRst;
      cfg_q.speed_epsilon    <= slsg_pkg::SpeedEpsilonRst;
    end else if (wr_en) begin
      unique case (idx)
        slsg_pkg::REG_STOP_MARGIN:      cfg_q.stop_margin      <= pwdata[30:0];
        slsg_pkg::REG_BRAKE_LATENCY:    cfg_q.brake_latency    <= pwdata[30:0];
        slsg_pkg::REG_STOP_BEGIN_RANGE: cfg_q.stop_begin_range <= pwdata[30:0];
        slsg_pkg::REG_MAX_DECELERATION: cfg_q.max_deceleration <= pwdata[30:0];
        slsg_pkg::REG_CREEP_RANGE_MAX:  cfg_q.creep_range_max  <= pwdata[30:0];
        slsg_pkg::REG_CREEP_SPEED:      cfg_q.creep_speed      <= pwdata[30:0];
        slsg_pkg::REG_BUMPER_OFFSET:    cfg_q.bumper_offset    <= pwdata[30:0];
        slsg_pkg::REG_SPEED_EPSILON:    cfg_q.speed_epsilon    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      slsg_pkg::REG_STOP_MARGIN:      prdata = {1'b0, cfg_q.stop_margin};
      slsg_pkg::REG_BRAKE_LATENCY:    prdata = {1'b0, cfg_q.brake_latency};
      slsg_pkg::REG_STOP_BEGIN_RANGE: prdata = {1'b0, cfg_q.stop_begin_range};
      slsg_pkg::REG_MAX_DECELERATION: prdata = {1'b0, cfg_q.max_deceleration};
      slsg_pkg::REG_CREEP_RANGE_MAX:  prdata = {1'b0, cfg_q.creep_range_max};
      slsg_pkg::REG_CREEP_SPEED:      prdata = {1'b0, cfg_q.creep_speed};
      slsg_pkg::REG_BUMPER_OFFSET:    prdata = {1'b0, cfg_q.bumper_offset};
      slsg_pkg::REG_SPEED_EPSILON:    prdata = {1'b0, cfg_q.speed_epsilon};
      default:                        prdata = '0;
    endcase
  end

endmodule

// ----- design/slsg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsg_div
// Restoring divider, one quotient bit per cycle, quotient saturates to all
// ones when it does not fit in 33 bits.
// ----------------------------------------------------------------------------
module slsg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        busy_o,
  output logic [32:0] quotient_o
);

  logic [slsg_pkg::DivCntW-1:0] cnt_q;
  logic [32:0]                  rem_q;
  logic [32:0]                  low_q;
  logic [32:0]                  dvs_q;
  logic                         ovf_q;
  logic [33:0]                  trial;
  logic                         ge;
  logic [33:0]                  diff;

  assign trial = {rem_q, low_q[32]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= slsg_pkg::DivCntW'(slsg_pkg::DivSteps);
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {3'b000, dividend_i[62:33]};
      low_q <= dividend_i[32:0];
      dvs_q <= divisor_i;
      // upper part already holds the divisor: quotient needs more than 33 bits
      ovf_q <= {3'b000, dividend_i[62:33]} >= divisor_i;
    end else if (busy_o) begin
      rem_q <= ge ? diff[32:0] : trial[32:0];
      low_q <= {low_q[31:0], ge};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = ovf_q ? '1 : low_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_o)
    else $error("divider started while busy");

endmodule

// ----- design/stop_line_speed_governor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_line_speed_governor
// Caps, halts or creeps the speed command near a stop waypoint.
// ----------------------------------------------------------------------------
// sequence: a control tick passes the latency, distance, square, divider start,
//   divide and decision states (33-step restoring divider forming v^2/(2D))
//   and a clear item goes straight to decision; one item at a time, and a result
//   waiting in the output register holds the next item off until it is taken
// reset: flags, speed at stop start and registers return to their reset values
module stop_line_speed_governor #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  slsg_stream_if.sink                   in_i,
  slsg_stream_if.source                 out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slsg_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic [63:0] VMax = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
  // deceleration only meets values below 2^32, so clamping there is exact
  localparam logic [32:0] ACap = (VALUE_WIDTH > 33) ? 33'h1_0000_0000 : VMax[32:0];
  localparam logic signed [31:0] CmdMax =
    (VALUE_WIDTH >= 32) ? 32'sh7FFF_FFFF : $signed(VMax[31:0]);
  localparam logic signed [31:0] CmdMin = ~CmdMax;

  slsg_pkg::cfg_t        cfg;
  slsg_pkg::slsg_state_e state_q, state_d;

  slsg_pkg::slsg_in_t    in_q;
  logic [31:0]           s_q;
  logic [31:0]           seff_q;
  logic signed [33:0]    base_q;
  logic signed [47:0]    d_q;
  logic [63:0]           prod_q;
  logic                  stop_q, creep_q;
  logic [30:0]           sast_q;
  slsg_pkg::slsg_out_t   out_q;
  logic                  out_valid_q;

  logic                  accept, dec_fire, div_start, div_busy;
  logic [32:0]           quotient;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod;

  slsg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[62:0]),
    .divisor_i  ({d_q[31:0], 1'b0}),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // ---------------- sequencer ----------------
  assign in_i.ready = state_q == slsg_pkg::ST_IDLE;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slsg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    dec_fire  = 1'b0;
    unique case (state_q)
      slsg_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.payload.opcode == slsg_pkg::OP_CLEAR) ?
                    slsg_pkg::ST_DEC : slsg_pkg::ST_LAT;
        end
      end
      slsg_pkg::ST_LAT:  state_d = slsg_pkg::ST_DIST;
      slsg_pkg::ST_DIST: state_d = slsg_pkg::ST_SQ;
      slsg_pkg::ST_SQ:   state_d = slsg_pkg::ST_DSTART;
      slsg_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_d   = slsg_pkg::ST_DIV;
      end
      slsg_pkg::ST_DIV: begin
        if (!div_busy) state_d = slsg_pkg::ST_DEC;
      end
      slsg_pkg::ST_DEC: begin
        if (!out_valid_q || out_o.ready) begin
          dec_fire = 1'b1;
          state_d  = slsg_pkg::ST_IDLE;
        end
      end
      default: state_d = slsg_pkg::ST_IDLE;
    endcase
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    if (state_q == slsg_pkg::ST_SQ) begin
      mul_a = seff_q;
      mul_b = seff_q;
    end else begin
      mul_a = s_q;
      mul_b = {1'b0, cfg.brake_latency};
    end
  end
  assign prod = mul_a * mul_b;

  // ---------------- decision ----------------
  logic               d_pos, trig, stop_now, fin;
  logic [32:0]        a_val;
  logic [31:0]        init;
  logic [30:0]        init_sat, sast_now;
  logic signed [34:0] slow_t, req35, m1, m2;
  logic signed [31:0] creep_cmd, cmd_raw, cmd_sat;
  logic               stop_d, creep_d;
  logic [30:0]        sast_d;

  always_comb begin
    d_pos    = !d_q[47] && (d_q != '0);
    a_val    = (d_pos && (quotient < ACap)) ? quotient : ACap;
    trig     = (d_q <= $signed({17'b0, cfg.stop_begin_range})) ||
               (a_val >= {2'b00, cfg.max_deceleration});
    init     = ({1'b0, in_q.top_speed} > seff_q) ? {1'b0, in_q.top_speed} : seff_q;
    init_sat = init[31] ? 31'h7FFF_FFFF : init[30:0];
    stop_now = stop_q || trig;
    sast_now = (trig && !stop_q) ? init_sat : sast_q;
    fin      = seff_q < {1'b0, cfg.speed_epsilon};

    req35  = {{3{in_q.requested_speed[31]}}, in_q.requested_speed};
    slow_t = $signed({3'b000, seff_q}) - $signed({2'b00, a_val});
    m1     = (req35 < slow_t) ? req35 : slow_t;
    m2     = (m1 < $signed({4'b0000, sast_now})) ? m1 : $signed({4'b0000, sast_now});
    creep_cmd = (in_q.requested_speed < $signed({1'b0, cfg.creep_speed})) ?
                in_q.requested_speed : $signed({1'b0, cfg.creep_speed});

    cmd_raw = in_q.requested_speed;
    creep_d = creep_q;
    stop_d  = stop_now;
    sast_d  = sast_now;
    if (stop_now) begin
      priority if ((d_q <= $signed({17'b0, cfg.stop_margin})) ||
                   in_q.inside_stop_polygon) begin
        cmd_raw = '0;
      end else if (!creep_q && !fin) begin
        // steady slowdown, never below zero
        cmd_raw = m2[34] ? 32'sd0 : m2[31:0];
      end else if (d_q <= $signed({17'b0, cfg.creep_range_max})) begin
        creep_d = 1'b1;
        cmd_raw = creep_cmd;
      end else begin
        // stopping but too far to creep: request passes
        cmd_raw = in_q.requested_speed;
      end
    end
    cmd_sat = (cmd_raw > CmdMax) ? CmdMax : ((cmd_raw < CmdMin) ? CmdMin : cmd_raw);
  end

  logic               halt_region;
  assign halt_region = stop_now && ((d_q <= $signed({17'b0, cfg.stop_margin})) ||
                                    in_q.inside_stop_polygon);

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q      <= 1'b0;
      creep_q     <= 1'b0;
      sast_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (dec_fire) begin
        if (in_q.opcode == slsg_pkg::OP_CLEAR) begin
          stop_q  <= 1'b0;
          creep_q <= 1'b0;
          sast_q  <= '0;
        end else begin
          stop_q  <= stop_d;
          creep_q <= creep_d;
          sast_q  <= sast_d;
        end
      end
      if (dec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i.payload;
      s_q  <= in_i.payload.measured_speed[31] ?
              (~in_i.payload.measured_speed + 32'd1) : in_i.payload.measured_speed;
    end
    if (state_q == slsg_pkg::ST_LAT) begin
      base_q <= $signed({3'b000, in_q.waypoint_distance}) +
                $signed({3'b000, cfg.stop_margin}) -
                $signed({3'b000, cfg.bumper_offset});
    end
    if (state_q == slsg_pkg::ST_LAT || state_q == slsg_pkg::ST_SQ) begin
      prod_q <= prod;
    end
    if (state_q == slsg_pkg::ST_DIST) begin
      d_q    <= {{14{base_q[33]}}, base_q} - $signed({2'b00, prod_q[61:16]});
      seff_q <= (s_q < {1'b0, cfg.speed_epsilon}) ? 32'd0 : s_q;
    end
    if (dec_fire) begin
      if (in_q.opcode == slsg_pkg::OP_CLEAR) begin
        out_q <= '0;
      end else begin
        out_q.commanded_speed <= cmd_sat;
        out_q.finished        <= halt_region && fin;
        out_q.is_stopping     <= stop_d;
        out_q.is_creeping     <= creep_d;
      end
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // ---------------- checks ----------------
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.finished |-> out_o.payload.is_stopping)
    else $error("finished reported without stopping");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.payload.is_creeping |-> out_o.payload.is_stopping)
    else $error("creeping reported without stopping");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(stop_q) |-> $past(dec_fire && (in_q.opcode == slsg_pkg::OP_CLEAR)))
    else $error("stopping flag dropped without a clear item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("new item taken while one is in progress");

endmodule

// ----- tb/tb_stop_line_speed_governor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stop_line_speed_governor
// Drives control ticks and clears into the stop line speed governor and
// checks every speed command against a cycle-free Q16.16 prediction. Runs
// directed corner items, then approach-to-stop sequences mixed with noise
// under several register settings, with random stalls on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_stop_line_speed_governor;

  localparam int unsigned One        = 65536;
  localparam longint      ValueMax   = 64'sd2147483647;
  localparam longint      ValueMin   = -ValueMax - 1;
  localparam longint      StartMax   = 64'sd2147483647;
  localparam int          CycleLimit = 800000;
  localparam int          HoldCycles = 300;

  // expected speed commands, computed from a local copy of registers and flags
  class speed_command_checker;
    logic [30:0]         regs [8];
    bit                  stopping;
    bit                  creeping;
    logic [30:0]         stop_start_speed;
    slsg_pkg::slsg_out_t expected_commands [$];
    int                  mismatches;

    function new();
      regs[slsg_pkg::REG_STOP_MARGIN]      = slsg_pkg::StopMarginRst;
      regs[slsg_pkg::REG_BRAKE_LATENCY]    = slsg_pkg::BrakeLatencyRst;
      regs[slsg_pkg::REG_STOP_BEGIN_RANGE] = slsg_pkg::StopBeginRangeRst;
      regs[slsg_pkg::REG_MAX_DECELERATION] = slsg_pkg::MaxDecelerationRst;
      regs[slsg_pkg::REG_CREEP_RANGE_MAX]  = slsg_pkg::CreepRangeMaxRst;
      regs[slsg_pkg::REG_CREEP_SPEED]      = slsg_pkg::CreepSpeedRst;
      regs[slsg_pkg::REG_BUMPER_OFFSET]    = slsg_pkg::BumperOffsetRst;
      regs[slsg_pkg::REG_SPEED_EPSILON]    = slsg_pkg::SpeedEpsilonRst;
      stopping         = 1'b0;
      creeping         = 1'b0;
      stop_start_speed = '0;
      mismatches       = 0;
    endfunction

    function void set_register(slsg_pkg::cfg_idx_e idx, logic [30:0] value);
      regs[idx] = value;
    endfunction

    function slsg_pkg::slsg_out_t predict_command(slsg_pkg::slsg_in_t it);
      longint              wd, meas, req, top, s, latdist, d, a, cmd, start;
      longint              margin, lat, begin_range, max_dec, creep_range, creep;
      longint              bumper, eps;
      slsg_pkg::slsg_out_t r;
      r = '0;
      if (it.opcode == slsg_pkg::OP_CLEAR) begin
        stopping         = 1'b0;
        creeping         = 1'b0;
        stop_start_speed = '0;
        return r;
      end
      wd          = it.waypoint_distance;
      meas        = it.measured_speed;
      req         = it.requested_speed;
      top         = it.top_speed;
      margin      = regs[slsg_pkg::REG_STOP_MARGIN];
      lat         = regs[slsg_pkg::REG_BRAKE_LATENCY];
      begin_range = regs[slsg_pkg::REG_STOP_BEGIN_RANGE];
      max_dec     = regs[slsg_pkg::REG_MAX_DECELERATION];
      creep_range = regs[slsg_pkg::REG_CREEP_RANGE_MAX];
      creep       = regs[slsg_pkg::REG_CREEP_SPEED];
      bumper      = regs[slsg_pkg::REG_BUMPER_OFFSET];
      eps         = regs[slsg_pkg::REG_SPEED_EPSILON];

      s       = (meas < 0) ? -meas : meas;
      latdist = (s * lat) >>> 16;
      d       = wd - bumper + margin - latdist;
      // standstill zeroing comes after the latency distance
      if (s < eps) s = 0;
      if (d <= 0) begin
        a = ValueMax;
      end else begin
        a = (s * s) / (2 * d);
        if (a > ValueMax) a = ValueMax;
      end

      if ((d <= begin_range || a >= max_dec) && !stopping) begin
        start    = (top > s) ? top : s;
        stopping = 1'b1;
        stop_start_speed = (start > StartMax) ? 31'h7fff_ffff : start[30:0];
      end

      cmd = req;
      if (stopping) begin
        if (d <= margin || it.inside_stop_polygon) begin
          cmd = 0;
          if (s < eps) r.finished = 1'b1;
        end else if (!creeping && s >= eps) begin
          if (s - a < cmd) cmd = s - a;
          if (longint'(stop_start_speed) < cmd) cmd = stop_start_speed;
          if (cmd < 0) cmd = 0;
        end else if (d <= creep_range) begin
          creeping = 1'b1;
          if (creep < cmd) cmd = creep;
        end
      end

      if (cmd > ValueMax) cmd = ValueMax;
      if (cmd < ValueMin) cmd = ValueMin;
      r.commanded_speed = cmd[31:0];
      r.is_stopping     = stopping;
      r.is_creeping     = creeping;
      return r;
    endfunction

    function void note_item(slsg_pkg::slsg_in_t it);
      expected_commands.push_back(predict_command(it));
    endfunction

    function void check_result(slsg_pkg::slsg_out_t got);
      slsg_pkg::slsg_out_t want;
      if (expected_commands.size() == 0) begin
        $error("result with nothing expected: commanded_speed %0d", got.commanded_speed);
        mismatches++;
        return;
      end
      want = expected_commands.pop_front();
      if (got.commanded_speed !== want.commanded_speed) begin
        $error("commanded_speed: expected %0d, got %0d",
               want.commanded_speed, got.commanded_speed);
        mismatches++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0b, got %0b", want.finished, got.finished);
        mismatches++;
      end
      if (got.is_stopping !== want.is_stopping) begin
        $error("is_stopping: expected %0b, got %0b", want.is_stopping, got.is_stopping);
        mismatches++;
      end
      if (got.is_creeping !== want.is_creeping) begin
        $error("is_creeping: expected %0b, got %0b", want.is_creeping, got.is_creeping);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [slsg_pkg::CfgAddrW-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  slsg_stream_if #(.payload_t(slsg_pkg::slsg_in_t))  in_if ();
  slsg_stream_if #(.payload_t(slsg_pkg::slsg_out_t)) out_if ();

  speed_command_checker board = new();

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_request = 1'b0;

  stop_line_speed_governor u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic slsg_pkg::slsg_in_t make_tick(logic [30:0] wd, logic [31:0] meas,
                                                   logic [31:0] req, logic [30:0] top,
                                                   logic in_poly);
    slsg_pkg::slsg_in_t it;
    it.opcode              = slsg_pkg::OP_TICK;
    it.waypoint_distance   = wd;
    it.measured_speed      = meas;
    it.requested_speed     = req;
    it.top_speed           = top;
    it.inside_stop_polygon = in_poly;
    return it;
  endfunction

  function automatic slsg_pkg::slsg_in_t noise_item();
    return make_tick(31'($urandom()), $urandom(), $urandom(), 31'($urandom()),
                     1'($urandom_range(1)));
  endfunction

  function automatic slsg_pkg::slsg_in_t clear_item();
    slsg_pkg::slsg_in_t it;
    it = noise_item();
    it.opcode = slsg_pkg::OP_CLEAR;
    return it;
  endfunction

  task automatic send_item(slsg_pkg::slsg_in_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_item(item);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (board.expected_commands.size() != 0) @(posedge clk_i);
  endtask

  // write, then read back the same register
  task automatic write_register(slsg_pkg::cfg_idx_e idx, logic [30:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {1'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_register(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[30:0] !== value) begin
      $error("%s: expected %0d, got %0d", idx.name(), value, prdata[30:0]);
      board.mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_typical(bit zero_eps);
    write_register(slsg_pkg::REG_STOP_MARGIN,      31'($urandom_range(2 * One)));
    write_register(slsg_pkg::REG_BRAKE_LATENCY,    31'($urandom_range(One / 2)));
    write_register(slsg_pkg::REG_STOP_BEGIN_RANGE, 31'($urandom_range(2 * One)));
    write_register(slsg_pkg::REG_MAX_DECELERATION, 31'($urandom_range(3 * One, One / 2)));
    write_register(slsg_pkg::REG_CREEP_RANGE_MAX,  31'($urandom_range(5 * One, One)));
    write_register(slsg_pkg::REG_CREEP_SPEED,      31'($urandom_range(One, One / 5)));
    write_register(slsg_pkg::REG_BUMPER_OFFSET,    31'($urandom_range(5 * One)));
    write_register(slsg_pkg::REG_SPEED_EPSILON,
                   zero_eps ? 31'd0 : 31'($urandom_range(2000)));
  endtask

  task automatic load_uniform(logic [30:0] value);
    int i;
    for (i = 0; i < 8; i++) write_register(slsg_pkg::cfg_idx_e'(i), value);
  endtask

  // a vehicle closing in on the stop line, slowing down, with random content
  task automatic approach_stop(input int limit, inout int sent);
    longint      gap, speed;
    logic [31:0] req, meas;
    logic [30:0] top;
    int          steps, k;
    gap   = longint'($urandom_range(40 * One));
    speed = longint'($urandom_range(15 * One));
    req   = $urandom_range(15 * One);
    top   = 31'($urandom_range(20 * One));
    steps = $urandom_range(30, 4);
    for (k = 0; k < steps && sent < limit; k++) begin
      meas = ($urandom_range(9) == 0) ? -speed[31:0] : speed[31:0];
      send_item(make_tick(gap[30:0], meas, req, top,
                          (k >= steps - 3) && $urandom_range(1)));
      sent++;
      gap = gap - (speed >>> 3) - longint'($urandom_range(One / 4));
      if (gap < 0) gap = 0;
      if ($urandom_range(3) == 0) speed = longint'($urandom_range(1000));
      else speed = speed - longint'($urandom_range(2 * One));
      if (speed < 0) speed = 0;
      if ($urandom_range(4) == 0) req = $urandom_range(15 * One);
    end
  endtask

  task automatic run_items(int count);
    int sent, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        approach_stop(count, sent);
      end else if (pick < 92) begin
        send_item(noise_item());
        sent++;
      end else begin
        send_item(clear_item());
        sent++;
      end
    end
  endtask

  task automatic run_directed();
    send_item(clear_item());
    // far away and slow: command passes through
    send_item(make_tick(31'(100 * One), 32'(One), 32'(2 * One), 31'(5 * One), 1'b0));
    // braking distance not positive, speeds at their top
    send_item(make_tick('0, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 1'b0));
    send_item(clear_item());
    // most negative speed: stop start speed saturates
    send_item(make_tick(31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, '0, 1'b0));
    send_item(make_tick(31'h7fff_ffff, 32'(5 * One), 32'(10 * One), 31'(3 * One), 1'b0));
    send_item(make_tick(31'(2 * One), 32'(3 * One), 32'(One), 31'(3 * One), 1'b1));
    send_item(make_tick(31'(2 * One), '0, 32'(One), 31'(3 * One), 1'b1));
    send_item(clear_item());
    // stop by deceleration, halt short, then creep
    send_item(make_tick(31'(5 * One), 32'(10 * One), 32'(8 * One), 31'(8 * One), 1'b0));
    send_item(make_tick(31'(5 * One), '0, 32'(2 * One), 31'(8 * One), 1'b0));
    send_item(make_tick(31'(5 * One), 32'(One), 32'(2 * One), 31'(8 * One), 1'b0));
    send_item(make_tick(31'(5 * One), 32'hffff_0000, 32'(2 * One), 31'(8 * One), 1'b0));
    // stopping, too far to creep: request passes
    send_item(make_tick(31'(10 * One), '0, 32'(2 * One), 31'(8 * One), 1'b0));
    send_item(make_tick(31'(10 * One), 32'd654, 32'(2 * One), 31'(8 * One), 1'b0));
    send_item(make_tick(31'(10 * One), 32'd655, 32'(2 * One), 31'(8 * One), 1'b0));
    send_item(clear_item());
    send_item(make_tick(31'(50 * One), 32'(2 * One), 32'h8000_0000, 31'h7fff_ffff, 1'b0));
    send_item(make_tick(31'(50 * One), 32'(2 * One), 32'h7fff_ffff, '0, 1'b1));
  endtask

  // result side: check, then pick ready for the next cycle
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) board.check_result(out_if.payload);
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_stop_line_speed_governor failed");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 17;
    snk_idle_pct = 52;
    run_directed();
    wait_drain();
    load_typical(1'b0);
    run_items(300);
    // sender pauses until every command is back
    wait_drain();
    run_items(150);
    wait_drain();

    src_idle_pct = 52;
    snk_idle_pct = 17;
    load_typical(1'b1);
    run_items(200);
    hold_request = 1'b1;
    run_items(200);
    wait_drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    load_uniform(31'h7fff_ffff);
    run_items(100);
    wait_drain();
    load_uniform('0);
    run_items(100);
    wait_drain();
    load_typical(1'b0);
    run_items(400);
    wait_drain();

    repeat (50) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("tb_stop_line_speed_governor passed");
    end else begin
      $display("tb_stop_line_speed_governor failed");
    end
    $finish;
  end

endmodule
